// ===== design/rrps_pkg.sv =====
// Shared types, constants and the control program of the round-robin scheduler.
`timescale 1ns / 1ps

package rrps_pkg;

  localparam int MAX_PROCS_DEF = 16;

  localparam int TQ_W     = 16;
  localparam int PC_W     = 5;
  localparam int SLOT_W   = 4;
  localparam int BT_W     = 16;
  localparam int AT_W     = 16;
  localparam int KIND_W   = 2;
  localparam int TIME_W   = 21;
  localparam int FCNT_W   = 5;
  localparam int CFG_W    = 16;
  localparam int CFG_IX_W = 1;

  localparam logic [TQ_W-1:0] TQ_RESET = 16'd4;
  localparam logic [PC_W-1:0] PC_RESET = 5'd1;

  typedef enum logic [CFG_IX_W-1:0] {
    REG_TIME_QUANTUM  = 1'b0,
    REG_PROCESS_COUNT = 1'b1
  } reg_idx_t;

  typedef enum logic [0:0] {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_RUN  = 2'd0,
    KIND_IDLE = 2'd1,
    KIND_DONE = 2'd2
  } kind_t;

  // Program steps
  typedef enum logic [3:0] {
    L_IDLE,
    L_DISP,
    L_ST0,
    L_SCAN,
    L_TEST,
    L_PASS_END,
    L_TICK,
    L_DONE,
    L_RUN,
    L_TAT,
    L_WAIT,
    L_EMIT,
    L_LD0,
    L_CP_RD,
    L_CP_WR
  } label_t;

  // Jump conditions
  typedef enum logic [3:0] {
    C_ALWAYS,
    C_NO_FIRE,
    C_IS_LOAD,
    C_DONE,
    C_IDX_END,
    C_NOT_RUNNABLE,
    C_RAN,
    C_OUT_BUSY,
    C_SLOT_BAD,
    C_IDX_FULL
  } cond_t;

  // Datapath actions
  typedef enum logic [3:0] {
    A_NONE,
    A_CAPTURE,
    A_IDX_START,
    A_SKIP,
    A_PASS_RESTART,
    A_TICK,
    A_DONE,
    A_RUN,
    A_TAT,
    A_WAIT,
    A_EMIT,
    A_LOAD,
    A_COPY
  } act_t;

  typedef struct packed {
    act_t   act;
    cond_t  cond;
    label_t on_true;
    label_t on_false;
  } ctrl_word_t;

  // Datapath flags seen by the sequencer
  typedef struct packed {
    logic fire;
    logic is_load;
    logic done;
    logic idx_end;
    logic not_runnable;
    logic ran;
    logic out_busy;
    logic slot_bad;
    logic idx_full;
  } status_t;

  // Action of the current step and whether its jump was taken
  typedef struct packed {
    act_t act;
    logic taken;
  } ctrl_t;

  // Control store
  function automatic ctrl_word_t ucode(input label_t l);
    ctrl_word_t w;
    case (l)
      L_IDLE:     w = '{A_CAPTURE,      C_NO_FIRE,      L_IDLE,     L_DISP};
      L_DISP:     w = '{A_NONE,         C_IS_LOAD,      L_LD0,      L_ST0};
      L_ST0:      w = '{A_IDX_START,    C_DONE,         L_DONE,     L_SCAN};
      L_SCAN:     w = '{A_NONE,         C_IDX_END,      L_PASS_END, L_TEST};
      L_TEST:     w = '{A_SKIP,         C_NOT_RUNNABLE, L_SCAN,     L_RUN};
      L_PASS_END: w = '{A_PASS_RESTART, C_RAN,          L_SCAN,     L_TICK};
      L_TICK:     w = '{A_TICK,         C_ALWAYS,       L_EMIT,     L_EMIT};
      L_DONE:     w = '{A_DONE,         C_ALWAYS,       L_EMIT,     L_EMIT};
      L_RUN:      w = '{A_RUN,          C_ALWAYS,       L_TAT,      L_TAT};
      L_TAT:      w = '{A_TAT,          C_ALWAYS,       L_WAIT,     L_WAIT};
      L_WAIT:     w = '{A_WAIT,         C_ALWAYS,       L_EMIT,     L_EMIT};
      L_EMIT:     w = '{A_EMIT,         C_OUT_BUSY,     L_EMIT,     L_IDLE};
      L_LD0:      w = '{A_LOAD,         C_SLOT_BAD,     L_IDLE,     L_CP_RD};
      L_CP_RD:    w = '{A_NONE,         C_IDX_FULL,     L_IDLE,     L_CP_WR};
      L_CP_WR:    w = '{A_COPY,         C_ALWAYS,       L_CP_RD,    L_CP_RD};
      default:    w = '{A_NONE,         C_ALWAYS,       L_IDLE,     L_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== design/round_robin_process_scheduler_top.sv =====
// Top level of the round-robin process scheduler: datapath, RAMs and sequencer.
`timescale 1ns / 1ps

// Round-robin scheduler with a fixed time quantum.
// Input channel (item_valid/item_stall): cmd selects a load of one process
// slot (burst_time, arrival_time) or one scheduling step. A load to a valid
// slot restarts the schedule, and a load gives no result; a step gives exactly
// one result item on the output channel (result_valid/result_stall).
// Configuration: cfg_write_en writes cfg_data into register cfg_index
// (0 time_quantum, 1 process_count) at the clock edge; write only while idle.
// Timing: items are processed one at a time by a microcoded sequencer.
// A step visits slots over up to two passes of process_count slots and ends
// in an idle tick, done or a slice. A load to a valid slot ends with a sweep
// that copies every burst of all MAX_PROCS slots into the remaining-time RAM.
// A finished result sits in the output register; when the receiver stalls,
// the next step waits in its emit step until the register is taken.
// Reset: time_quantum 4, process_count 1, clock and pass state zero, no
// result pending, input stalled while rst is high. Slot RAMs are undefined.
module round_robin_process_scheduler_top
  import rrps_pkg::*;
#(
  parameter int MAX_PROCS = MAX_PROCS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_en,
  input  logic [CFG_IX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic                cmd,
  input  logic [SLOT_W-1:0]   slot,
  input  logic [BT_W-1:0]     burst_time,
  input  logic [AT_W-1:0]     arrival_time,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [KIND_W-1:0]   kind,
  output logic [SLOT_W-1:0]   process,
  output logic [BT_W-1:0]     slice_length,
  output logic [TIME_W-1:0]   time_after,
  output logic                finished,
  output logic [TIME_W-1:0]   turnaround,
  output logic [TIME_W-1:0]   waiting
);

  localparam int AW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam int PW = (CW > PC_W) ? CW : PC_W;
  localparam int PROG_W = BT_W + AT_W;

  // Configuration and schedule state
  logic [TQ_W-1:0]   tq;
  logic [PC_W-1:0]   pc;
  logic [TIME_W-1:0] clock_cnt;
  logic [AW-1:0]     ptr;
  logic              ran;
  logic [FCNT_W-1:0] fin_cnt;

  // Captured item and working registers
  logic              it_cmd;
  logic [SLOT_W-1:0] it_slot;
  logic [BT_W-1:0]   it_burst;
  logic [AT_W-1:0]   it_arr;
  logic [CW-1:0]     idx;
  logic              rem_zero;
  logic [TIME_W-1:0] tat;

  // Staged result
  logic [KIND_W-1:0] res_kind;
  logic [SLOT_W-1:0] res_proc;
  logic [BT_W-1:0]   res_slice;
  logic [TIME_W-1:0] res_time;
  logic              res_fin;
  logic [TIME_W-1:0] res_tat;
  logic [TIME_W-1:0] res_wait;

  // RAM ports
  logic              prog_we;
  logic [PROG_W-1:0] prog_wdata;
  logic [PROG_W-1:0] prog_rdata;
  logic              rem_we;
  logic [BT_W-1:0]   rem_wdata;
  logic [BT_W-1:0]   rem_rdata;
  logic [BT_W-1:0]   rd_burst;
  logic [AT_W-1:0]   rd_arr;

  // Derived values
  logic [PW-1:0]     pc_ext;
  logic [PW-1:0]     n_sat;
  logic [CW-1:0]     n;
  logic [CW-1:0]     ptr_ext;
  logic [CW-1:0]     start_idx;
  logic [CW-1:0]     idx_inc;
  logic [TQ_W-1:0]   q;
  logic [BT_W-1:0]   sl;
  logic [BT_W-1:0]   burst_fix;
  logic              emit_now;

  status_t status;
  ctrl_t   ctrl;

  rrps_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  // Burst and arrival per slot
  rrps_ram #(.WIDTH(PROG_W), .DEPTH(MAX_PROCS)) u_prog_ram (
    .clk   (clk),
    .we    (prog_we),
    .waddr (AW'(it_slot)),
    .wdata (prog_wdata),
    .raddr (idx[AW-1:0]),
    .rdata (prog_rdata)
  );

  // Remaining work per slot
  rrps_ram #(.WIDTH(BT_W), .DEPTH(MAX_PROCS)) u_rem_ram (
    .clk   (clk),
    .we    (rem_we),
    .waddr (idx[AW-1:0]),
    .wdata (rem_wdata),
    .raddr (idx[AW-1:0]),
    .rdata (rem_rdata)
  );

  // Datapath combinational logic
  always_comb begin
    rd_burst   = prog_rdata[PROG_W-1:AT_W];
    rd_arr     = prog_rdata[AT_W-1:0];
    pc_ext     = PW'(pc);
    n_sat      = (pc_ext > PW'(MAX_PROCS)) ? PW'(MAX_PROCS) : pc_ext;
    n          = n_sat[CW-1:0];
    ptr_ext    = CW'(ptr);
    start_idx  = (ptr_ext < n) ? ptr_ext : n;
    idx_inc    = idx + CW'(1);
    q          = (tq == '0) ? TQ_W'(1) : tq;
    sl         = (rem_rdata > q) ? q : rem_rdata;
    burst_fix  = (it_burst == '0) ? BT_W'(1) : it_burst;
    prog_we    = (ctrl.act == A_LOAD) && !ctrl.taken;
    prog_wdata = {burst_fix, it_arr};
    rem_we     = (ctrl.act == A_RUN) || (ctrl.act == A_COPY);
    rem_wdata  = (ctrl.act == A_RUN) ? (rem_rdata - sl) : rd_burst;
    emit_now   = (ctrl.act == A_EMIT) && !ctrl.taken;
    item_stall = rst || (ctrl.act != A_CAPTURE);

    status.fire         = item_valid;
    status.is_load      = (it_cmd == CMD_LOAD);
    status.done         = (PW'(fin_cnt) >= n_sat);
    status.idx_end      = (idx >= n);
    status.not_runnable = !((TIME_W'(rd_arr) <= clock_cnt) && (rem_rdata != '0));
    status.ran          = ran;
    status.out_busy     = result_valid && result_stall;
    status.slot_bad     = (32'(it_slot) >= 32'(MAX_PROCS));
    status.idx_full     = (idx >= CW'(MAX_PROCS));
  end

  // Configuration registers and schedule state
  always_ff @(posedge clk) begin
    if (rst) begin
      tq           <= TQ_RESET;
      pc           <= PC_RESET;
      clock_cnt    <= '0;
      ptr          <= '0;
      ran          <= 1'b0;
      fin_cnt      <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        case (reg_idx_t'(cfg_index))
          REG_TIME_QUANTUM:  tq <= cfg_data[TQ_W-1:0];
          REG_PROCESS_COUNT: pc <= cfg_data[PC_W-1:0];
          default: ;
        endcase
      end

      // Hold the result until taken
      if (emit_now) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end

      case (ctrl.act)
        A_PASS_RESTART: begin
          ptr <= '0;
          ran <= 1'b0;
        end
        A_TICK: begin
          clock_cnt <= clock_cnt + TIME_W'(1);
          ptr       <= '0;
          ran       <= 1'b0;
        end
        A_RUN: begin
          clock_cnt <= clock_cnt + TIME_W'(sl);
          // Wrap to slot 0 at the end of the pass
          if (idx_inc >= n) begin
            ptr <= '0;
            ran <= 1'b0;
          end else begin
            ptr <= AW'(idx_inc);
            ran <= 1'b1;
          end
        end
        A_TAT: begin
          if (rem_zero) begin
            fin_cnt <= fin_cnt + FCNT_W'(1);
          end
        end
        A_LOAD: begin
          // Restart the schedule
          if (!ctrl.taken) begin
            clock_cnt <= '0;
            ptr       <= '0;
            ran       <= 1'b0;
            fin_cnt   <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers and staged result
  always_ff @(posedge clk) begin
    case (ctrl.act)
      A_CAPTURE: begin
        if (!ctrl.taken) begin
          it_cmd   <= cmd;
          it_slot  <= slot;
          it_burst <= burst_time;
          it_arr   <= arrival_time;
        end
      end
      A_IDX_START: idx <= start_idx;
      A_SKIP: begin
        if (ctrl.taken) begin
          idx <= idx_inc;
        end
      end
      A_PASS_RESTART: idx <= '0;
      A_TICK: begin
        res_kind  <= KIND_IDLE;
        res_proc  <= '0;
        res_slice <= '0;
        res_time  <= clock_cnt + TIME_W'(1);
        res_fin   <= 1'b0;
        res_tat   <= '0;
        res_wait  <= '0;
      end
      A_DONE: begin
        res_kind  <= KIND_DONE;
        res_proc  <= '0;
        res_slice <= '0;
        res_time  <= clock_cnt;
        res_fin   <= 1'b0;
        res_tat   <= '0;
        res_wait  <= '0;
      end
      A_RUN: begin
        res_kind  <= KIND_RUN;
        res_proc  <= SLOT_W'(idx);
        res_slice <= sl;
        rem_zero  <= (rem_rdata == sl);
      end
      A_TAT: tat <= clock_cnt - TIME_W'(rd_arr);
      A_WAIT: begin
        res_time <= clock_cnt;
        res_fin  <= rem_zero;
        res_tat  <= rem_zero ? tat : '0;
        res_wait <= rem_zero ? (tat - TIME_W'(rd_burst)) : '0;
      end
      A_LOAD: begin
        if (!ctrl.taken) begin
          idx <= '0;
        end
      end
      A_COPY: idx <= idx_inc;
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (emit_now) begin
      kind         <= res_kind;
      process      <= res_proc;
      slice_length <= res_slice;
      time_after   <= res_time;
      finished     <= res_fin;
      turnaround   <= res_tat;
      waiting      <= res_wait;
    end
  end

endmodule

// ===== design/rrps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rrps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/rrps_seq.sv =====
// Microcode sequencer: step counter, control store lookup and jump logic.
`timescale 1ns / 1ps

module rrps_seq
  import rrps_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output ctrl_t   ctrl
);

  label_t     upc;
  label_t     upc_next;
  ctrl_word_t word;
  logic       hit;

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= L_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  // Decode the current word and pick the next step
  always_comb begin
    word = ucode(upc);
    case (word.cond)
      C_ALWAYS:       hit = 1'b1;
      C_NO_FIRE:      hit = !status.fire;
      C_IS_LOAD:      hit = status.is_load;
      C_DONE:         hit = status.done;
      C_IDX_END:      hit = status.idx_end;
      C_NOT_RUNNABLE: hit = status.not_runnable;
      C_RAN:          hit = status.ran;
      C_OUT_BUSY:     hit = status.out_busy;
      C_SLOT_BAD:     hit = status.slot_bad;
      C_IDX_FULL:     hit = status.idx_full;
      default:        hit = 1'b0;
    endcase
    upc_next   = hit ? word.on_true : word.on_false;
    ctrl.act   = word.act;
    ctrl.taken = hit;
  end

endmodule
